// ===== hw/rtl/aws_pkg.sv =====
// Shared constants, codes and types for the aligned window splitter.
package aws_pkg;

   localparam int MAX_TABLES      = 8;
   localparam int MIN_WINDOW_LOG2 = 12;

   // Entry counter must hold MAX_TABLES itself and carry at least a 3-bit index.
   localparam int USED_CNT_W = ($clog2(MAX_TABLES + 1) > 3) ? $clog2(MAX_TABLES + 1) : 3;

   localparam int ADDR_W       = 32;
   localparam int LOG2_W       = 5;
   localparam int INDEX_W      = 3;
   localparam int ATTR_W       = 19;
   localparam int REQ_TDATA_W  = 104;
   localparam int REQ_TUSER_W  = 2;
   localparam int RSP_TDATA_W  = 88;

   localparam logic [ATTR_W-1:0] ATTR_IO  = 19'h20001;
   localparam logic [ATTR_W-1:0] ATTR_MEM = 19'h00000;
   localparam logic [ADDR_W-1:0] ENABLE_BIT = 32'h0000_0001;

   localparam logic [1:0] RES_TYPE_IO  = 2'd0;
   localparam logic [1:0] RES_TYPE_MEM = 2'd1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_TYPE  = 2'd1,
      STATUS_TOO_SMALL = 2'd2,
      STATUS_NO_TABLES = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SEARCH,
      ST_EMIT,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/aligned_window_splitter.sv =====
// Splits an address region into aligned power-of-two translation windows.
// Each window takes a check, search steps down from the top window size and an emit;
// the closing status beat is sent from the done state after a check or a failed search.
// One region at a time: a new region is accepted only once the closing status beat of the
// last is issued. Search steps are single shift-and-compares; beats wait for rsp_tready.
// Reset (synchronous, active high) returns the sequencer to idle, drops any pending
// beat and clears the used-entry count; no clearing pass is needed.
module aligned_window_splitter
   import aws_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // restart [0], cpu_base [32:1], bus_base [64:33], region_size [96:65], zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // res_type [1:0]
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // table_index [2:0], src_word [34:3], translated_addr [66:35],
   // attr_word [85:67], status [87:86]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // is_window [0]
   output logic [0:0]             rsp_tuser,
   output logic                   rsp_tlast
);

   localparam logic [LOG2_W-1:0] MIN_LG = LOG2_W'(MIN_WINDOW_LOG2);
   localparam logic [LOG2_W-1:0] TOP_LG = LOG2_W'(ADDR_W - 1);
   localparam logic [USED_CNT_W-1:0] USED_MAX = USED_CNT_W'(MAX_TABLES);

   state_type               state_ff, state_in;
   logic [ADDR_W-1:0]       cpu_ff, cpu_in;
   logic [ADDR_W-1:0]       pci_ff, pci_in;
   logic [ADDR_W-1:0]       rem_ff, rem_in;
   logic [ATTR_W-1:0]       attr_ff, attr_in;
   logic                    type_ok_ff, type_ok_in;
   logic [LOG2_W-1:0]       lg_ff, lg_in;
   logic [USED_CNT_W-1:0]   used_ff, used_in;
   status_type              status_ff, status_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_win_ff, rsp_win_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [INDEX_W-1:0]      rsp_index_ff, rsp_index_in;
   logic [ADDR_W-1:0]       rsp_src_ff, rsp_src_in;
   logic [ADDR_W-1:0]       rsp_trsl_ff, rsp_trsl_in;
   logic [ATTR_W-1:0]       rsp_attr_ff, rsp_attr_in;
   status_type              rsp_status_ff, rsp_status_in;

   logic [ADDR_W-1:0]       cand;
   logic                    fits;
   logic                    out_free;
   logic [LOG2_W:0]         lg_m1;
   logic [ADDR_W-1:0]       size_code;

   // Shared search step: the candidate window and its fit test against the region.
   assign cand     = ADDR_W'(1) << lg_ff;
   assign fits     = (cand <= rem_ff) && ((cpu_ff & (cand - ADDR_W'(1))) == '0);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // A one-byte window wraps log2 - 1 to all ones in the size code field.
   assign lg_m1     = {1'b0, lg_ff} - (LOG2_W+1)'(1);
   assign size_code = {{(ADDR_W-LOG2_W-2){1'b0}}, lg_m1, 1'b0};

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_win_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {rsp_status_ff, rsp_attr_ff, rsp_trsl_ff, rsp_src_ff, rsp_index_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cpu_ff        <= cpu_in;
      pci_ff        <= pci_in;
      rem_ff        <= rem_in;
      attr_ff       <= attr_in;
      type_ok_ff    <= type_ok_in;
      lg_ff         <= lg_in;
      status_ff     <= status_in;
      rsp_win_ff    <= rsp_win_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_src_ff    <= rsp_src_in;
      rsp_trsl_ff   <= rsp_trsl_in;
      rsp_attr_ff   <= rsp_attr_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      cpu_in        = cpu_ff;
      pci_in        = pci_ff;
      rem_in        = rem_ff;
      attr_in       = attr_ff;
      type_ok_in    = type_ok_ff;
      lg_in         = lg_ff;
      used_in       = used_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_win_in    = rsp_win_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_src_in    = rsp_src_ff;
      rsp_trsl_in   = rsp_trsl_ff;
      rsp_attr_in   = rsp_attr_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cpu_in     = req_tdata[32:1];
               pci_in     = req_tdata[64:33];
               rem_in     = req_tdata[96:65];
               type_ok_in = (req_tuser == RES_TYPE_IO) || (req_tuser == RES_TYPE_MEM);
               attr_in    = (req_tuser == RES_TYPE_IO) ? ATTR_IO : ATTR_MEM;
               if (req_tdata[0]) begin
                  used_in = '0;
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            lg_in = TOP_LG;
            if (!type_ok_ff) begin
               status_in = STATUS_BAD_TYPE;
               state_in  = ST_DONE;
            end else if (rem_ff == '0) begin
               status_in = STATUS_OK;
               state_in  = ST_DONE;
            end else if (used_ff >= USED_MAX) begin
               status_in = STATUS_NO_TABLES;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // Walk the window size down until it fits the length and the alignment, or fail at the minimum.
            if (fits) begin
               state_in = ST_EMIT;
            end else if (lg_ff <= MIN_LG) begin
               status_in = STATUS_TOO_SMALL;
               state_in  = ST_DONE;
            end else begin
               lg_in = lg_ff - LOG2_W'(1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_win_in    = 1'b1;
               rsp_last_in   = 1'b0;
               rsp_index_in  = used_ff[INDEX_W-1:0];
               rsp_src_in    = cpu_ff | size_code | ENABLE_BIT;
               rsp_trsl_in   = pci_ff;
               rsp_attr_in   = attr_ff;
               rsp_status_in = STATUS_OK;
               cpu_in        = cpu_ff + cand;
               pci_in        = pci_ff + cand;
               rem_in        = rem_ff - cand;
               used_in       = used_ff + USED_CNT_W'(1);
               state_in      = ST_CHECK;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_win_in    = 1'b0;
               rsp_last_in   = 1'b1;
               rsp_index_in  = '0;
               rsp_src_in    = '0;
               rsp_trsl_in   = '0;
               rsp_attr_in   = '0;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_MAX)
      else $error("entry count beyond table size");

   a_window_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_win_ff |-> !rsp_last_ff && rsp_src_ff[0])
      else $error("window beat marked last or not enabled");

   a_search_floor: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> lg_ff >= MIN_LG)
      else $error("size search went below the minimum window");

   a_accept_checks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_CHECK)
      else $error("accepted region not checked next cycle");

   a_emit_fits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> fits && used_ff < USED_MAX)
      else $error("emitting a window that does not fit");

endmodule

// ===== bench/aligned_window_splitter_tb.sv =====
// Self-checking bench for the aligned window splitter: regions in, window and status beats out.
`timescale 1ns / 100ps

module aligned_window_splitter_tb
   import aws_pkg::*;
();

   localparam int unsigned RUN_LIMIT     = 1000000;
   localparam int unsigned RANDOM_COUNT  = 460;
   localparam int unsigned HOLD_START    = 3000;
   localparam int unsigned HOLD_END      = 5000;
   localparam int unsigned DRAIN_CYCLES  = 100;
   localparam logic [ADDR_W-1:0] CODE_MASK = 32'h0000_007E;
   localparam logic [1:0] RES_TYPE_BAD2 = 2'd2;
   localparam logic [1:0] RES_TYPE_BAD3 = 2'd3;

   typedef struct {
      logic              restart;
      logic [1:0]        res_type;
      logic [ADDR_W-1:0] cpu_base;
      logic [ADDR_W-1:0] bus_base;
      logic [ADDR_W-1:0] region_size;
   } region_type;

   typedef struct {
      logic               is_window;
      logic [INDEX_W-1:0] table_index;
      logic [ADDR_W-1:0]  src_word;
      logic [ADDR_W-1:0]  translated_addr;
      logic [ATTR_W-1:0]  attr_word;
      status_type         status;
      logic               last;
   } table_beat_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [0:0]             rsp_tuser;
   logic                   rsp_tlast;

   region_type     pending_regions[$];
   table_beat_type expected_beats[$];
   region_type     offered_region;
   int unsigned entries_used = 0;
   int unsigned regions_taken = 0;
   int unsigned beats_seen = 0;
   int unsigned send_gap = 0;
   int unsigned recv_stall = 0;
   int unsigned hold_clock = 0;
   int unsigned run_clock = 0;
   logic        hold_active = 1'b0;
   int          errors = 0;

   always #2 clock = ~clock;

   aligned_window_splitter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   function automatic int unsigned top_set_bit(logic [ADDR_W-1:0] v);
      for (int i = ADDR_W - 1; i > 0; i--)
         if (v[i]) return i;
      return 0;
   endfunction

   function automatic int unsigned low_set_bit(logic [ADDR_W-1:0] v);
      for (int i = 0; i < ADDR_W - 1; i++)
         if (v[i]) return i;
      return ADDR_W - 1;
   endfunction

   task automatic push_status(status_type code);
      table_beat_type b;
      b = '{1'b0, '0, '0, '0, '0, code, 1'b1};
      expected_beats.push_back(b);
   endtask

   // Works out the window beats and the closing status beat for one accepted region.
   task automatic split_region(region_type r);
      logic [ADDR_W-1:0] cpu;
      logic [ADDR_W-1:0] pci;
      logic [ADDR_W-1:0] left;
      logic [ADDR_W-1:0] step;
      logic [ADDR_W-1:0] code;
      logic [ATTR_W-1:0] attr;
      int unsigned       lg;
      table_beat_type    b;
      if (r.restart) entries_used = 0;
      if (r.res_type == RES_TYPE_IO) begin
         attr = ATTR_IO;
      end else if (r.res_type == RES_TYPE_MEM) begin
         attr = ATTR_MEM;
      end else begin
         push_status(STATUS_BAD_TYPE);
         return;
      end
      cpu  = r.cpu_base;
      pci  = r.bus_base;
      left = r.region_size;
      while (left != 0 && entries_used < MAX_TABLES) begin
         lg = top_set_bit(left);
         if (cpu != 0 && low_set_bit(cpu) < lg) lg = low_set_bit(cpu);
         if (lg < MIN_WINDOW_LOG2) begin
            push_status(STATUS_TOO_SMALL);
            return;
         end
         code = ((ADDR_W'(lg) - 32'd1) << 1) & CODE_MASK;
         b = '{1'b1, INDEX_W'(entries_used), cpu | code | ENABLE_BIT, pci, attr, STATUS_OK, 1'b0};
         expected_beats.push_back(b);
         step = 32'd1 << lg;
         cpu  = cpu + step;
         pci  = pci + step;
         left = left - step;
         entries_used++;
      end
      push_status(left != 0 ? STATUS_NO_TABLES : STATUS_OK);
   endtask

   task automatic add_region(logic restart, logic [1:0] res_type, logic [ADDR_W-1:0] cpu,
                             logic [ADDR_W-1:0] pci, logic [ADDR_W-1:0] size);
      region_type r;
      r = '{restart, res_type, cpu, pci, size};
      pending_regions.push_back(r);
   endtask

   function automatic region_type random_region();
      region_type  r;
      int unsigned kind;
      int unsigned align;
      kind       = $urandom_range(0, 99);
      r.restart  = ($urandom_range(0, 2) == 0);
      r.res_type = (kind < 8) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
      r.bus_base = $urandom;
      if (kind < 80) begin
         // Aligned bases and 4 KiB multiples, so most regions yield real windows.
         align         = $urandom_range(MIN_WINDOW_LOG2, ADDR_W - 1);
         r.cpu_base    = $urandom & ~((32'd1 << align) - 32'd1);
         if ($urandom_range(0, 3) == 0)
            r.region_size = $urandom & 32'hFFFF_F000;
         else
            r.region_size = 32'($urandom_range(1, 63)) << $urandom_range(MIN_WINDOW_LOG2, 26);
      end else begin
         r.cpu_base    = $urandom;
         r.region_size = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
      end
      return r;
   endfunction

   task automatic check_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
      if (want !== got) begin
         $error("%s expected %h actual %h", name, want, got);
         errors++;
      end
   endtask

   task automatic check_beat();
      table_beat_type want;
      if (expected_beats.size() == 0) begin
         $error("unexpected result beat, tdata %h tuser %h tlast %b",
                rsp_tdata, rsp_tuser, rsp_tlast);
         errors++;
         return;
      end
      want = expected_beats.pop_front();
      check_field("is_window", 32'(want.is_window), 32'(rsp_tuser[0]));
      check_field("table_index", 32'(want.table_index), 32'(rsp_tdata[2:0]));
      check_field("src_word", want.src_word, rsp_tdata[34:3]);
      check_field("translated_addr", want.translated_addr, rsp_tdata[66:35]);
      check_field("attr_word", 32'(want.attr_word), 32'(rsp_tdata[85:67]));
      check_field("status", 32'(want.status), 32'(rsp_tdata[87:86]));
      check_field("last", 32'(want.last), 32'(rsp_tlast));
   endtask

   // Sender: offers pending regions, predicting each one on the beat it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            split_region(offered_region);
            regions_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_regions.size() != 0) begin
               offered_region = pending_regions.pop_front();
               req_tdata  <= {7'b0, offered_region.region_size, offered_region.bus_base,
                              offered_region.cpu_base, offered_region.restart};
               req_tuser  <= offered_region.res_type;
               req_tvalid <= 1'b1;
               send_gap   = ((regions_taken / 40) % 2 == 1) ? 0 : $urandom_range(0, 11);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks every taken beat and stalls at random between beats.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_beat();
            beats_seen++;
            recv_stall = ((beats_seen / 64) % 2 == 1) ? 0 : $urandom_range(0, 11);
         end
         if (hold_active) begin
            rsp_tready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // A long receiver hold-off early in the run, so the block backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_clock  <= 0;
         hold_active <= 1'b0;
      end else begin
         hold_clock  <= hold_clock + 1;
         hold_active <= (hold_clock >= HOLD_START && hold_clock < HOLD_END);
      end
   end

   always @(posedge clock) begin
      run_clock <= run_clock + 1;
      if (run_clock == RUN_LIMIT) begin
         $display("aligned_window_splitter_tb failed");
         $finish;
      end
   end

   initial begin
      // Edge cases first: both types, unknown types, empty and tiny regions,
      // misaligned bases, address wrap, and running out of table entries.
      add_region(1'b1, RES_TYPE_IO,   32'h1000_0000, 32'h8000_0000, 32'h1000_0000);
      add_region(1'b1, RES_TYPE_MEM,  32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
      add_region(1'b0, RES_TYPE_BAD2, 32'h0000_0000, 32'h0000_0000, 32'h0000_1000);
      add_region(1'b0, RES_TYPE_MEM,  32'h4000_0000, 32'h0000_0000, 32'h0000_1000);
      add_region(1'b0, RES_TYPE_IO,   32'h4000_0000, 32'h0000_0000, 32'h0000_0000);
      add_region(1'b1, RES_TYPE_BAD3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_region(1'b1, RES_TYPE_IO,   32'h0000_1800, 32'h1234_5000, 32'h0001_0000);
      add_region(1'b1, RES_TYPE_MEM,  32'h2000_0000, 32'h3000_0000, 32'h0000_1800);
      add_region(1'b1, RES_TYPE_MEM,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      add_region(1'b1, RES_TYPE_MEM,  32'hFFFF_F000, 32'hFFFF_E000, 32'h0000_3000);
      add_region(1'b1, RES_TYPE_IO,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_region(1'b1, RES_TYPE_IO,   32'h8000_0000, 32'h7FFF_F000, 32'h8000_0000);
      add_region(1'b1, RES_TYPE_MEM,  32'h0000_0000, 32'h0000_0000, 32'h0000_1000);
      add_region(1'b1, RES_TYPE_MEM,  32'h0000_0000, 32'h0000_0000, 32'h0000_0FFF);
      add_region(1'b1, RES_TYPE_IO,   32'h0001_0000, 32'hABCD_0000, 32'h0001_F000);
      add_region(1'b0, RES_TYPE_MEM,  32'h5000_0000, 32'h6000_0000, 32'h0000_7000);
      add_region(1'b0, RES_TYPE_IO,   32'h0000_0000, 32'h0000_0000, 32'h0000_1000);
      add_region(1'b0, RES_TYPE_BAD2, 32'h0000_0000, 32'h0000_0000, 32'h0000_1000);
      add_region(1'b1, RES_TYPE_MEM,  32'h0000_3000, 32'h0000_0000, 32'h0000_3000);
      add_region(1'b1, RES_TYPE_IO,   32'hFFFF_F000, 32'h0000_0000, 32'hFFFF_F000);
      for (int i = 0; i < RANDOM_COUNT; i++)
         pending_regions.push_back(random_region());

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Sampling on the falling edge keeps these checks clear of the clocked processes.
      do @(negedge clock);
      while (pending_regions.size() != 0 || req_tvalid || expected_beats.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_beats.size() != 0) begin
         $error("%0d expected beats never arrived", expected_beats.size());
         errors++;
      end
      if (errors == 0)
         $display("aligned_window_splitter_tb passed");
      else
         $display("aligned_window_splitter_tb failed");
      $finish;
   end

endmodule
